>>> hw/rtl/brd_pkg.sv
// ----------------------------------------------------------------------------
// brd_pkg: shared types and constants of the byte run-length decoder
// Field widths, the phase encoding, status codes and the item and
// result records passed between the stages.
// ----------------------------------------------------------------------------
package brd_pkg;

    // Token layout and varint limits
    localparam int TYPE_BITS = 2;
    localparam int LEN_BITS  = 24;
    localparam int TAG_POS   = 7 - TYPE_BITS;
    localparam logic [7:0] TAG_MASK = 8'((1 << TAG_POS) - 1);

    // Fixed field widths
    localparam int CNT_W      = 24;
    localparam int STATUS_W   = 3;
    localparam int TDATA_IN_W = 8;
    localparam int TDATA_W    = 40;
    localparam int CMP_W      = (LEN_BITS + 1 > CNT_W) ? LEN_BITS + 1 : CNT_W;

    // Run types
    localparam int unsigned RT_ZERO    = 0;
    localparam int unsigned RT_ONES    = 1;
    localparam int unsigned RT_REPEAT  = 2;
    localparam int unsigned RT_LITERAL = 3;

    // Decoder phase
    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_TOK0  = 3'd2,
        PH_TOK1  = 3'd3,
        PH_WAITB = 3'd4,
        PH_LIT   = 3'd5,
        PH_DRAIN = 3'd6
    } phase_t;

    // Status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_OVERRUN    = 3'd1,
        ST_UNEXPECTED = 3'd2,
        ST_MISMATCH   = 3'd3,
        ST_TOOLARGE   = 3'd4
    } status_t;

    // Output kind
    localparam logic KIND_RUN    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // One input request
    typedef struct packed {
        logic       cmd;
        logic [7:0] code_byte;
        logic       end_of_stream;
    } item_t;

    // One result
    typedef struct packed {
        logic             out_kind;
        logic [7:0]       byte_value;
        logic [CNT_W-1:0] repeat_count;
        status_t          status;
        logic             last_flag;
    } result_t;

endpackage

>>> hw/rtl/brd_in_stage.sv
// ----------------------------------------------------------------------------
// brd_in_stage: input register
// Captures one request from the slave channel and hands it to the
// decoder core when the result register can take its outcome.
// ----------------------------------------------------------------------------
module brd_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  brd_pkg::item_t s_item,
    input  logic           out_free,
    output logic           fire,
    output brd_pkg::item_t item
);

    logic           valid_reg;
    brd_pkg::item_t item_reg;

    // Advance the held request when the result side has room
    assign fire    = valid_reg && out_free;
    assign s_ready = !valid_reg || fire;
    assign item    = item_reg;

    // Control: hold or refill the stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (fire) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

>>> hw/rtl/brd_core.sv
// ----------------------------------------------------------------------------
// brd_core: run-length token decoder
// Holds the stream state, folds one byte per request into it and forms
// the run descriptor or status result that the byte causes.
// ----------------------------------------------------------------------------
module brd_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [brd_pkg::CNT_W-1:0] cfg_wr_data,
    input  logic                      fire,
    input  brd_pkg::item_t            item,
    output logic                      res_valid,
    output brd_pkg::result_t          res
);

    localparam int LB = brd_pkg::LEN_BITS;
    localparam int CW = brd_pkg::CNT_W;
    localparam int MW = brd_pkg::CMP_W;

    // State
    logic [CW-1:0]                 output_size_reg;
    brd_pkg::phase_t               phase_reg, phase_next;
    logic [LB-1:0]                 acc_reg, acc_next;
    logic [brd_pkg::TYPE_BITS-1:0] rt_reg, rt_next;
    logic [CW-1:0]                 lit_reg, lit_next;
    logic [LB-1:0]                 ctrl_reg, ctrl_next;
    logic [CW-1:0]                 prod_reg, prod_next;
    brd_pkg::status_t              err_reg, err_next;

    // Working values
    logic [7:0]                    b;
    logic                          acc_ovf;
    logic [LB-1:0]                 acc_pushed;
    logic [LB-1:0]                 acc_first;
    logic [LB-1:0]                 hdr_val;
    logic [LB-1:0]                 acc_tok;
    logic [brd_pkg::TYPE_BITS-1:0] tok_type;
    logic                          tok_end;
    logic [CW-1:0]                 avail;
    logic [MW-1:0]                 len_cmp;
    logic [CW-1:0]                 len;
    logic [CW-1:0]                 lit_dec;
    brd_pkg::status_t              err;
    brd_pkg::status_t              final_st;
    logic                          have;
    logic [7:0]                    rv;
    logic [CW-1:0]                 rc;

    assign b          = item.code_byte;
    assign acc_ovf    = |acc_reg[LB-1 -: 7];
    assign acc_pushed = {acc_reg[LB-8:0], b[6:0]};
    assign acc_first  = LB'(b & brd_pkg::TAG_MASK);
    assign hdr_val    = (phase_reg == brd_pkg::PH_HDR0) ? LB'(b[6:0]) : acc_pushed;
    assign avail      = (output_size_reg > prod_reg) ? (output_size_reg - prod_reg) : '0;
    assign len_cmp    = MW'(acc_tok) + MW'(1);
    assign len        = CW'(len_cmp);
    assign lit_dec    = (lit_reg != '0) ? (lit_reg - CW'(1)) : '0;

    // Next state and result for one byte
    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        rt_next    = rt_reg;
        lit_next   = lit_reg;
        ctrl_next  = ctrl_reg;
        prod_next  = prod_reg;
        err_next   = err_reg;
        err        = brd_pkg::ST_OK;
        have       = 1'b0;
        rv         = '0;
        rc         = '0;
        tok_end    = 1'b0;
        acc_tok    = acc_reg;
        tok_type   = rt_reg;
        final_st   = brd_pkg::ST_OK;
        res_valid  = 1'b0;
        res        = '0;

        if (fire) begin
            // Phase work
            case (phase_reg)
                brd_pkg::PH_HDR0, brd_pkg::PH_HDR1: begin
                    if (item.cmd) begin
                        err = brd_pkg::ST_UNEXPECTED;
                    end else if (phase_reg == brd_pkg::PH_HDR1 && acc_ovf) begin
                        err = brd_pkg::ST_TOOLARGE;
                    end else if (b[7]) begin
                        acc_next   = hdr_val;
                        phase_next = brd_pkg::PH_HDR1;
                    end else begin
                        ctrl_next  = hdr_val;
                        acc_next   = '0;
                        phase_next = brd_pkg::PH_TOK0;
                    end
                end
                brd_pkg::PH_TOK0: begin
                    if (item.cmd || ctrl_reg == '0) begin
                        err = brd_pkg::ST_UNEXPECTED;
                    end else begin
                        ctrl_next = ctrl_reg - LB'(1);
                        rt_next   = b[7 -: brd_pkg::TYPE_BITS];
                        tok_type  = b[7 -: brd_pkg::TYPE_BITS];
                        if (b[brd_pkg::TAG_POS] && ctrl_reg > LB'(1)) begin
                            acc_next   = acc_first;
                            phase_next = brd_pkg::PH_TOK1;
                        end else begin
                            tok_end = 1'b1;
                            acc_tok = acc_first;
                        end
                    end
                end
                brd_pkg::PH_TOK1: begin
                    if (item.cmd) begin
                        err = brd_pkg::ST_UNEXPECTED;
                    end else begin
                        ctrl_next = ctrl_reg - LB'(1);
                        if (acc_ovf) begin
                            err = brd_pkg::ST_TOOLARGE;
                        end else if (b[7] && ctrl_reg > LB'(1)) begin
                            acc_next = acc_pushed;
                        end else begin
                            tok_end = 1'b1;
                            acc_tok = acc_pushed;
                        end
                    end
                end
                brd_pkg::PH_WAITB: begin
                    if (!item.cmd) begin
                        err = brd_pkg::ST_UNEXPECTED;
                    end else begin
                        have       = 1'b1;
                        rv         = b;
                        rc         = lit_reg;
                        prod_next  = prod_reg + lit_reg;
                        lit_next   = '0;
                        phase_next = brd_pkg::PH_TOK0;
                    end
                end
                brd_pkg::PH_LIT: begin
                    if (!item.cmd) begin
                        err = brd_pkg::ST_UNEXPECTED;
                    end else begin
                        have      = 1'b1;
                        rv        = b;
                        rc        = CW'(1);
                        prod_next = prod_reg + CW'(1);
                        lit_next  = lit_dec;
                        if (lit_dec == '0) begin
                            phase_next = brd_pkg::PH_TOK0;
                        end
                    end
                end
                default: begin
                end
            endcase

            // Finish a token: check its length against the room left
            if (tok_end) begin
                acc_next = '0;
                if (len_cmp > MW'(avail)) begin
                    err = brd_pkg::ST_OVERRUN;
                end else begin
                    phase_next = brd_pkg::PH_TOK0;
                    if (32'(tok_type) == brd_pkg::RT_ZERO ||
                        32'(tok_type) == brd_pkg::RT_ONES) begin
                        have      = 1'b1;
                        rv        = (32'(tok_type) == brd_pkg::RT_ZERO) ? 8'h00 : 8'hFF;
                        rc        = len;
                        prod_next = prod_reg + len;
                    end else if (32'(tok_type) == brd_pkg::RT_REPEAT) begin
                        lit_next   = len;
                        phase_next = brd_pkg::PH_WAITB;
                    end else if (32'(tok_type) == brd_pkg::RT_LITERAL) begin
                        lit_next   = len;
                        phase_next = brd_pkg::PH_LIT;
                    end
                end
            end

            // Latch the first fault and drain
            if (err != brd_pkg::ST_OK) begin
                err_next   = err;
                phase_next = brd_pkg::PH_DRAIN;
                have       = 1'b0;
            end

            // Form the result
            if (item.end_of_stream) begin
                final_st = err_next;
                if (err_next == brd_pkg::ST_OK) begin
                    final_st = (phase_next == brd_pkg::PH_TOK0 && ctrl_next == '0 &&
                                prod_next == output_size_reg) ?
                               brd_pkg::ST_OK : brd_pkg::ST_MISMATCH;
                end
                res_valid        = 1'b1;
                res.out_kind     = brd_pkg::KIND_STATUS;
                res.byte_value   = have ? rv : 8'h00;
                res.repeat_count = have ? rc : '0;
                res.status       = final_st;
                res.last_flag    = 1'b1;
                // Return to the start of a new stream
                phase_next = brd_pkg::PH_HDR0;
                acc_next   = '0;
                rt_next    = '0;
                lit_next   = '0;
                ctrl_next  = '0;
                prod_next  = '0;
                err_next   = brd_pkg::ST_OK;
            end else if (err != brd_pkg::ST_OK) begin
                res_valid    = 1'b1;
                res.out_kind = brd_pkg::KIND_STATUS;
                res.status   = err;
            end else if (have) begin
                res_valid        = 1'b1;
                res.out_kind     = brd_pkg::KIND_RUN;
                res.byte_value   = rv;
                res.repeat_count = rc;
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            output_size_reg <= '0;
            phase_reg       <= brd_pkg::PH_HDR0;
            acc_reg         <= '0;
            rt_reg          <= '0;
            lit_reg         <= '0;
            ctrl_reg        <= '0;
            prod_reg        <= '0;
            err_reg         <= brd_pkg::ST_OK;
        end else begin
            if (cfg_wr_en) begin
                output_size_reg <= cfg_wr_data;
            end
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            rt_reg    <= rt_next;
            lit_reg   <= lit_next;
            ctrl_reg  <= ctrl_next;
            prod_reg  <= prod_next;
            err_reg   <= err_next;
        end
    end

endmodule

>>> hw/rtl/brd_out_stage.sv
// ----------------------------------------------------------------------------
// brd_out_stage: result register
// Holds one result for the master channel and frees itself in the
// same cycle the receiver takes it.
// ----------------------------------------------------------------------------
module brd_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  brd_pkg::result_t res,
    output logic             out_free,
    output logic             m_valid,
    input  logic             m_ready,
    output brd_pkg::result_t m_res
);

    logic             valid_reg;
    brd_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    // Control: load a new result or drop the taken one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

>>> hw/rtl/byte_rle_run_decoder.sv
// ----------------------------------------------------------------------------
// byte_rle_run_decoder: byte run-length decoder with run descriptor output
// Top level: input register, decoder core, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one coded byte per request in s_tdata, the stream select
//   in s_tuser (0 control, 1 data) and s_tlast on the final byte of a stream.
//   Master channel: at most one result per request; m_tuser is 0 for a run
//   descriptor (value, count) and 1 for a status item; m_tlast marks the
//   final status item that closes a stream.
//   cfg_wr_en/cfg_wr_data set the expected decoded size; write it only while
//   no request is in flight.
// Flow:
//   A byte accepted into the input register is decoded by the core once the
//   result register has room, and its result is then loaded into the result
//   register, from which it shows on the master side. The decode state
//   updates once per byte, so the block sustains one byte per cycle while
//   the receiver takes results; bytes that yield no result do not load the
//   result register but still wait until it has room.
// Reset (aresetn low, synchronous) empties both registers and returns the
// decoder to the start of a stream with an expected size of zero.
// When the receiver stalls the result is held; at most one more byte enters
// the input register, after which s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module byte_rle_run_decoder (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration
    input  logic                        cfg_wr_en,
    input  logic [brd_pkg::CNT_W-1:0]   cfg_wr_data,
    // Slave channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [brd_pkg::TDATA_IN_W-1:0] s_tdata,  // [7:0] code_byte
    input  logic                        s_tuser,     // [0] cmd
    input  logic                        s_tlast,     // end_of_stream
    // Master channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [brd_pkg::TDATA_W-1:0] m_tdata,     // [7:0] byte_value,
                                                     // [31:8] repeat_count,
                                                     // [34:32] status, rest 0
    output logic                        m_tuser,     // [0] out_kind
    output logic                        m_tlast      // last_flag
);

    brd_pkg::item_t   s_item;
    brd_pkg::item_t   core_item;
    logic             core_fire;
    logic             core_res_valid;
    brd_pkg::result_t core_res;
    brd_pkg::result_t m_res;
    logic             out_free;

    // Gather the slave fields
    assign s_item.cmd           = s_tuser;
    assign s_item.code_byte     = s_tdata;
    assign s_item.end_of_stream = s_tlast;

    brd_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_item   (s_item),
        .out_free (out_free),
        .fire     (core_fire),
        .item     (core_item)
    );

    brd_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (core_fire),
        .item        (core_item),
        .res_valid   (core_res_valid),
        .res         (core_res)
    );

    brd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (core_fire && core_res_valid),
        .res      (core_res),
        .out_free (out_free),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (m_res)
    );

    // Pack the master fields
    assign m_tdata = brd_pkg::TDATA_W'({m_res.status, m_res.repeat_count, m_res.byte_value});
    assign m_tuser = m_res.out_kind;
    assign m_tlast = m_res.last_flag;

`ifndef SYNTHESIS
    // Every end-of-stream byte closes its stream with a result
    a_eos_result: assert property (@(posedge aclk) disable iff (!aresetn)
        core_fire && core_item.end_of_stream |-> core_res_valid && core_res.last_flag)
        else $error("end of stream produced no final result");

    // A run descriptor carries no status and no last flag
    a_run_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> !m_tlast && m_tdata[34:32] == brd_pkg::ST_OK)
        else $error("run descriptor carries status");

    // A run descriptor never describes zero bytes
    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[31:8] != '0)
        else $error("empty run descriptor");

    // A status item before the end of the stream is always a fault
    a_mid_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && !m_tlast |-> m_tdata[34:32] != brd_pkg::ST_OK)
        else $error("status item without fault before end of stream");
`endif

endmodule
